@@ sv/nnd_pkg.sv @@
package nnd_pkg;

	localparam int DIM_W = 9;
	localparam int OY_W = 6;
	localparam int CH_W = 8;
	localparam int OP_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int DIV_W = OY_W + DIM_W;
	localparam int OUT_SIZE_DEF = 50;
	localparam int MAX_SOURCE_DIM_DEF = 256;
	localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;
	localparam logic [DIM_W-1:0] ROW_SAT = 9'd511;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH = 2'd0,
		OP_REPLAY = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_WIDTH = 1'b0,
		REG_SOURCE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIV_CUR,
		DIV_NEXT,
		DIV_WIDTH
	} div_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CUR,
		ST_PEND,
		ST_WID,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic push;
		logic replay;
		logic restart;
		logic div_start;
		div_sel_t div_sel;
		logic pend_set;
		logic step_init;
		logic issue;
		logic row_adv;
	} cmd_t;

	typedef struct packed {
		logic col_last;
		logic row_zero;
		logic col_zero;
		logic finished;
		logic div_busy;
		logic match;
		logic last_row;
		logic ox_last;
		logic out_free;
	} sts_t;

endpackage

@@ sv/nearest_neighbour_downscaler.sv @@
// channel  | handshake            | payload
// in       | in_valid / in_ready  | operation, red_in, green_in, blue_in, alpha_in
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
// out      | out_valid / out_ready| rgba out, out_column, out_line, flags
// a push that does not end a row, a restart or an ignored item is taken without leaving idle
// a row end or replay that emits nothing makes one divider pass and a decision
// an emitted row makes divider passes for the current row, the next row (not on the
// last row) and the width, a setup step and OUT_SIZE issues, one pixel a cycle from the
// line store port while out_ready allows; input is held off while a row is computed or
// emitted; reset clears the source counters, sets both sizes to 256, keeps the line store
module nearest_neighbour_downscaler #(
	parameter int OUT_SIZE = nnd_pkg::OUT_SIZE_DEF,
	parameter int MAX_SOURCE_DIM = nnd_pkg::MAX_SOURCE_DIM_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [nnd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nnd_pkg::DIM_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [nnd_pkg::OP_W-1:0]        operation,
	input  logic [nnd_pkg::CH_W-1:0]        red_in,
	input  logic [nnd_pkg::CH_W-1:0]        green_in,
	input  logic [nnd_pkg::CH_W-1:0]        blue_in,
	input  logic [nnd_pkg::CH_W-1:0]        alpha_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [nnd_pkg::CH_W-1:0]        red_out,
	output logic [nnd_pkg::CH_W-1:0]        green_out,
	output logic [nnd_pkg::CH_W-1:0]        blue_out,
	output logic [nnd_pkg::CH_W-1:0]        alpha_out,
	output logic [nnd_pkg::OY_W-1:0]        out_column,
	output logic [nnd_pkg::OY_W-1:0]        out_line,
	output logic                            row_last,
	output logic                            replay_pending,
	output logic                            image_done
);

	nnd_pkg::cmd_t cmd;
	nnd_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	nnd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd)
	);

	nnd_dp #(
		.OUT_SIZE       (OUT_SIZE),
		.MAX_SOURCE_DIM (MAX_SOURCE_DIM)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.red_in         (red_in),
		.green_in       (green_in),
		.blue_in        (blue_in),
		.alpha_in       (alpha_in),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.red_out        (red_out),
		.green_out      (green_out),
		.blue_out       (blue_out),
		.alpha_out      (alpha_out),
		.out_column     (out_column),
		.out_line       (out_line),
		.row_last       (row_last),
		.replay_pending (replay_pending),
		.image_done     (image_done)
	);

endmodule

@@ sv/nnd_ctrl.sv @@
module nnd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       operation,
	input  nnd_pkg::sts_t    sts,
	output nnd_pkg::cmd_t    cmd
);

	nnd_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nnd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			nnd_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (operation)
						nnd_pkg::OP_PUSH: begin
							if (!sts.finished && sts.col_last) state_d = nnd_pkg::ST_CUR;
						end
						nnd_pkg::OP_REPLAY: begin
							if (!sts.finished && !sts.row_zero && sts.col_zero)
								state_d = nnd_pkg::ST_CUR;
						end
						default: state_d = nnd_pkg::ST_IDLE;
					endcase
				end
			end
			nnd_pkg::ST_CUR: begin
				if (!sts.div_busy) begin
					if (!sts.match) state_d = nnd_pkg::ST_IDLE;
					else if (sts.last_row) state_d = nnd_pkg::ST_WID;
					else state_d = nnd_pkg::ST_PEND;
				end
			end
			nnd_pkg::ST_PEND: begin
				if (!sts.div_busy) state_d = nnd_pkg::ST_WID;
			end
			nnd_pkg::ST_WID: begin
				if (!sts.div_busy) state_d = nnd_pkg::ST_EMIT;
			end
			nnd_pkg::ST_EMIT: begin
				if (sts.out_free && sts.ox_last) state_d = nnd_pkg::ST_IDLE;
			end
			default: state_d = nnd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.div_sel = nnd_pkg::DIV_CUR;
		in_ready = 1'b0;
		case (state_q)
			nnd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (operation)
						nnd_pkg::OP_PUSH: begin
							if (!sts.finished) begin
								cmd.push = 1'b1;
								cmd.div_start = sts.col_last;
							end
						end
						nnd_pkg::OP_REPLAY: begin
							if (!sts.finished && !sts.row_zero && sts.col_zero) begin
								cmd.replay = 1'b1;
								cmd.div_start = 1'b1;
							end
						end
						nnd_pkg::OP_RESTART: cmd.restart = 1'b1;
						default: cmd = '0;
					endcase
				end
			end
			nnd_pkg::ST_CUR: begin
				if (!sts.div_busy && sts.match) begin
					cmd.div_start = 1'b1;
					if (sts.last_row) begin
						cmd.pend_set = 1'b1;
						cmd.div_sel = nnd_pkg::DIV_WIDTH;
					end else begin
						cmd.div_sel = nnd_pkg::DIV_NEXT;
					end
				end
			end
			nnd_pkg::ST_PEND: begin
				if (!sts.div_busy) begin
					cmd.pend_set = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel = nnd_pkg::DIV_WIDTH;
				end
			end
			nnd_pkg::ST_WID: begin
				cmd.step_init = !sts.div_busy;
			end
			nnd_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.issue = 1'b1;
					cmd.row_adv = sts.ox_last;
				end
			end
			default: cmd = '0;
		endcase
	end

endmodule

@@ sv/nnd_dp.sv @@
module nnd_dp #(
	parameter int OUT_SIZE = nnd_pkg::OUT_SIZE_DEF,
	parameter int MAX_SOURCE_DIM = nnd_pkg::MAX_SOURCE_DIM_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [nnd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nnd_pkg::DIM_W-1:0]       cfg_data,
	input  logic [nnd_pkg::CH_W-1:0]        red_in,
	input  logic [nnd_pkg::CH_W-1:0]        green_in,
	input  logic [nnd_pkg::CH_W-1:0]        blue_in,
	input  logic [nnd_pkg::CH_W-1:0]        alpha_in,
	input  nnd_pkg::cmd_t                   cmd,
	output nnd_pkg::sts_t                   sts,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [nnd_pkg::CH_W-1:0]        red_out,
	output logic [nnd_pkg::CH_W-1:0]        green_out,
	output logic [nnd_pkg::CH_W-1:0]        blue_out,
	output logic [nnd_pkg::CH_W-1:0]        alpha_out,
	output logic [nnd_pkg::OY_W-1:0]        out_column,
	output logic [nnd_pkg::OY_W-1:0]        out_line,
	output logic                            row_last,
	output logic                            replay_pending,
	output logic                            image_done
);

	localparam int DIM_W = nnd_pkg::DIM_W;
	localparam int OY_W = nnd_pkg::OY_W;
	localparam int DW = nnd_pkg::DIV_W;
	localparam int AW = (MAX_SOURCE_DIM > 1) ? $clog2(MAX_SOURCE_DIM) : 1;
	localparam int RW = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
	localparam int CW = 2;
	localparam int PW = 4 * nnd_pkg::CH_W;
	localparam int SH = DW + RW;
	localparam logic [DW+1:0] RECIP =
		(DW + 2)'(((64'd1 << SH) + 64'(OUT_SIZE) - 64'd1) / 64'(OUT_SIZE));
	localparam logic [RW:0] OUT_V = (RW + 1)'(OUT_SIZE);
	localparam logic [OY_W-1:0] OX_LAST = OY_W'(OUT_SIZE - 1);

	logic [DIM_W-1:0] width_q, height_q;
	logic [DIM_W-1:0] w_cl, h_cl;
	logic [DIM_W-1:0] col_q, row_q, rsel_q;
	logic [OY_W-1:0] orow_q, ox_q;
	logic finished_q, pend_q;
	logic [DW-1:0] div_x_q;
	logic [DW-1:0] div_n_q;
	logic [RW-1:0] div_r_q;
	logic [CW-1:0] div_cnt_q;
	logic div_busy_q;
	logic [DIM_W-1:0] qw_q, sx_q;
	logic [RW-1:0] rw_q, srem_q;
	logic [PW-1:0] mem [MAX_SOURCE_DIM];
	logic [PW-1:0] rd_s1;
	logic out_valid_s1;
	logic [OY_W-1:0] col_s1, line_s1;
	logic last_s1, pend_s1, done_s1;
	logic [DW-1:0] dividend;
	logic [2*DW+1:0] recip_prod;
	logic [DW-1:0] quot, back_prod;
	logic [RW:0] srem_sum;
	logic srem_ge, last_row;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) r = DIM_W'(1);
		else if (32'(v) > MAX_SOURCE_DIM) r = DIM_W'(MAX_SOURCE_DIM);
		else r = v;
		return r;
	endfunction

	assign w_cl = clamp_dim(width_q);
	assign h_cl = clamp_dim(height_q);
	assign last_row = (32'(orow_q) + 1) >= OUT_SIZE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= nnd_pkg::DIM_RESET;
			height_q <= nnd_pkg::DIM_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				nnd_pkg::REG_SOURCE_WIDTH: width_q <= cfg_data;
				nnd_pkg::REG_SOURCE_HEIGHT: height_q <= cfg_data;
				default: width_q <= width_q;
			endcase
		end
	end

	// source counters and row bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			orow_q <= '0;
			finished_q <= 1'b0;
			rsel_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (cmd.restart) begin
				col_q <= '0;
				row_q <= '0;
				orow_q <= '0;
				finished_q <= 1'b0;
			end
			if (cmd.push) begin
				if ((10'(col_q) + 10'd1) < 10'(w_cl)) begin
					col_q <= col_q + DIM_W'(1);
				end else begin
					col_q <= '0;
					rsel_q <= row_q;
					if (row_q != nnd_pkg::ROW_SAT) row_q <= row_q + DIM_W'(1);
				end
			end
			if (cmd.replay) rsel_q <= row_q - DIM_W'(1);
			if (cmd.pend_set) pend_q <= sts.match && !last_row;
			if (cmd.row_adv) begin
				if (last_row) finished_q <= 1'b1;
				else orow_q <= orow_q + OY_W'(1);
			end
		end
	end

	// division by the output size through a reciprocal product, quotient then remainder
	always_comb begin
		case (cmd.div_sel)
			nnd_pkg::DIV_CUR: dividend = DW'(orow_q) * DW'(h_cl);
			nnd_pkg::DIV_NEXT: dividend = DW'(orow_q + OY_W'(1)) * DW'(h_cl);
			nnd_pkg::DIV_WIDTH: dividend = DW'(w_cl);
			default: dividend = '0;
		endcase
	end

	assign recip_prod = (2 * DW + 2)'(div_x_q) * (2 * DW + 2)'(RECIP);
	assign quot = DW'(recip_prod >> SH);
	assign back_prod = div_n_q * DW'(OUT_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_busy_q <= 1'b1;
			div_cnt_q <= CW'(2);
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q - CW'(1);
			if (div_cnt_q == CW'(1)) div_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_x_q <= dividend;
		end else if (div_busy_q) begin
			if (div_cnt_q == CW'(2)) div_n_q <= quot;
			else div_r_q <= RW'(div_x_q - back_prod);
		end
	end

	// column stepping: sx advances by w / OUT_SIZE with remainder carry
	assign srem_sum = {1'b0, srem_q} + {1'b0, rw_q};
	assign srem_ge = srem_sum >= OUT_V;

	always_ff @(posedge clk) begin
		if (cmd.step_init) begin
			qw_q <= div_n_q[DIM_W-1:0];
			rw_q <= div_r_q;
			sx_q <= '0;
			srem_q <= '0;
			ox_q <= '0;
		end else if (cmd.issue) begin
			ox_q <= ox_q + OY_W'(1);
			srem_q <= RW'(srem_ge ? srem_sum - OUT_V : srem_sum);
			sx_q <= sx_q + qw_q + DIM_W'(srem_ge);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) mem[AW'(col_q)] <= {alpha_in, blue_in, green_in, red_in};
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_s1 <= mem[AW'(sx_q)];
			col_s1 <= ox_q;
			line_s1 <= orow_q;
			last_s1 <= ox_q == OX_LAST;
			pend_s1 <= pend_q;
			done_s1 <= (ox_q == OX_LAST) && last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (cmd.issue) begin
			out_valid_s1 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s1 <= 1'b0;
		end
	end

	always_comb begin
		sts.col_last = (10'(col_q) + 10'd1) >= 10'(w_cl);
		sts.row_zero = row_q == '0;
		sts.col_zero = col_q == '0;
		sts.finished = finished_q;
		sts.div_busy = div_busy_q;
		sts.match = div_n_q[DIM_W-1:0] == rsel_q;
		sts.last_row = last_row;
		sts.ox_last = ox_q == OX_LAST;
		sts.out_free = !out_valid_s1 || out_ready;
	end

	assign out_valid = out_valid_s1;
	assign red_out = rd_s1[7:0];
	assign green_out = rd_s1[15:8];
	assign blue_out = rd_s1[23:16];
	assign alpha_out = rd_s1[31:24];
	assign out_column = col_s1;
	assign out_line = line_s1;
	assign row_last = last_s1;
	assign replay_pending = pend_s1;
	assign image_done = done_s1;

	a_issue_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (!out_valid_s1 || out_ready))
		else $error("pixel issued into a full output stage");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy_q)
		else $error("divider restarted while busy");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.row_adv && last_row) |=> finished_q)
		else $error("final row emitted without finishing");

	a_issue_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |=> out_valid_s1)
		else $error("issued pixel not presented");

endmodule

@@ dv/tb_nearest_neighbour_downscaler.sv @@
`timescale 1ns / 1ps

module tb_nearest_neighbour_downscaler;

	localparam int OUT_SIZE = nnd_pkg::OUT_SIZE_DEF;
	localparam int MAX_DIM = nnd_pkg::MAX_SOURCE_DIM_DEF;
	localparam logic [nnd_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE = 3 * (nnd_pkg::DIV_W + 1) + OUT_SIZE + 20;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [5:0] column;
		logic [5:0] line;
		logic last;
		logic pending;
		logic done;
	} pixel_t;

	class downscale_scoreboard;
		pixel_t expected_pixels[$];
		logic [31:0] line_copy[MAX_DIM];
		int unsigned column;
		int unsigned src_row;
		int unsigned out_row;
		bit finished;
		logic [nnd_pkg::DIM_W-1:0] width_reg;
		logic [nnd_pkg::DIM_W-1:0] height_reg;
		int errors;

		function new();
			width_reg = nnd_pkg::DIM_RESET;
			height_reg = nnd_pkg::DIM_RESET;
		endfunction

		function int unsigned dim(logic [nnd_pkg::DIM_W-1:0] v);
			if (v == 0) return 1;
			if (v > MAX_DIM) return MAX_DIM;
			return v;
		endfunction

		function int unsigned mapped_row(int unsigned oy);
			return oy * dim(height_reg) / OUT_SIZE;
		endfunction

		function void set_reg(logic [nnd_pkg::CFG_IDX_W-1:0] idx,
				logic [nnd_pkg::DIM_W-1:0] v);
			if (idx == nnd_pkg::REG_SOURCE_WIDTH) width_reg = v;
			else height_reg = v;
		endfunction

		function bit replay_applies();
			return !finished && src_row != 0 && column == 0 &&
				mapped_row(out_row) == src_row - 1;
		endfunction

		// a replay was missed, no later row can match until restart
		function bit image_stuck();
			return !finished && (mapped_row(out_row) + 1 < src_row ||
				(mapped_row(out_row) + 1 == src_row && column != 0));
		endfunction

		function void emit_line(int unsigned src);
			int unsigned w;
			int unsigned oy;
			int unsigned sx;
			bit last_row;
			bit pend;
			pixel_t p;
			logic [31:0] word;
			w = dim(width_reg);
			oy = out_row;
			last_row = (oy + 1 >= OUT_SIZE);
			pend = !last_row && mapped_row(oy + 1) == src;
			for (int ox = 0; ox < OUT_SIZE; ox++) begin
				sx = ox * w / OUT_SIZE;
				word = line_copy[sx % MAX_DIM];
				p.red = word[7:0];
				p.green = word[15:8];
				p.blue = word[23:16];
				p.alpha = word[31:24];
				p.column = 6'(ox);
				p.line = 6'(oy);
				p.last = (ox == OUT_SIZE - 1);
				p.pending = pend;
				p.done = p.last && last_row;
				expected_pixels.push_back(p);
			end
			if (last_row) finished = 1'b1;
			else out_row = oy + 1;
		endfunction

		// returns 1 when the transaction changed state or produced pixels
		function bit note_item(logic [nnd_pkg::OP_W-1:0] op, logic [31:0] px);
			int unsigned r;
			case (op)
				nnd_pkg::OP_RESTART: begin
					column = 0;
					src_row = 0;
					out_row = 0;
					finished = 1'b0;
					return 1'b1;
				end
				nnd_pkg::OP_REPLAY: begin
					if (!replay_applies()) return 1'b0;
					emit_line(src_row - 1);
					return 1'b1;
				end
				nnd_pkg::OP_PUSH: begin
					if (finished) return 1'b0;
					line_copy[column % MAX_DIM] = px;
					if (column + 1 < dim(width_reg)) begin
						column = (column + 1) & 32'h1FF;
						return 1'b1;
					end
					column = 0;
					r = src_row;
					if (src_row < nnd_pkg::ROW_SAT) src_row++;
					if (mapped_row(out_row) == r) emit_line(r);
					return 1'b1;
				end
				default: return 1'b0;
			endcase
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (expected_pixels.size() == 0) begin
				$error("output transaction with no expected pixel");
				errors++;
				return;
			end
			want = expected_pixels.pop_front();
			compare_field("red_out", want.red, got.red);
			compare_field("green_out", want.green, got.green);
			compare_field("blue_out", want.blue, got.blue);
			compare_field("alpha_out", want.alpha, got.alpha);
			compare_field("out_column", 8'(want.column), 8'(got.column));
			compare_field("out_line", 8'(want.line), 8'(got.line));
			compare_field("row_last", 8'(want.last), 8'(got.last));
			compare_field("replay_pending", 8'(want.pending), 8'(got.pending));
			compare_field("image_done", 8'(want.done), 8'(got.done));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [nnd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [nnd_pkg::DIM_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [nnd_pkg::OP_W-1:0] operation;
	logic [nnd_pkg::CH_W-1:0] red_in;
	logic [nnd_pkg::CH_W-1:0] green_in;
	logic [nnd_pkg::CH_W-1:0] blue_in;
	logic [nnd_pkg::CH_W-1:0] alpha_in;
	logic out_valid;
	logic out_ready;
	logic [nnd_pkg::CH_W-1:0] red_out;
	logic [nnd_pkg::CH_W-1:0] green_out;
	logic [nnd_pkg::CH_W-1:0] blue_out;
	logic [nnd_pkg::CH_W-1:0] alpha_out;
	logic [nnd_pkg::OY_W-1:0] out_column;
	logic [nnd_pkg::OY_W-1:0] out_line;
	logic row_last;
	logic replay_pending;
	logic image_done;

	downscale_scoreboard sb = new();
	bit stall_free;
	bit item_counted;
	int cycle_count;

	nearest_neighbour_downscaler dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_pixel(pixel_t'{red_out, green_out, blue_out, alpha_out,
				out_column, out_line, row_last, replay_pending, image_done});
		end
	end

	function automatic int gap_len();
		if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_free || $urandom_range(0, 3) != 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				repeat (gap_len() - 1) @(posedge clk);
			end
		end
	end

	task automatic idle_in();
		int n;
		n = (stall_free || $urandom_range(0, 2) != 0) ? 0 : gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_item(logic [nnd_pkg::OP_W-1:0] op, logic [31:0] px);
		operation <= op;
		red_in <= px[7:0];
		green_in <= px[15:8];
		blue_in <= px[23:16];
		alpha_in <= px[31:24];
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		item_counted = sb.note_item(op, px);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_dims(logic [nnd_pkg::DIM_W-1:0] w, logic [nnd_pkg::DIM_W-1:0] h);
		cfg_index <= nnd_pkg::REG_SOURCE_WIDTH;
		cfg_data <= w;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(nnd_pkg::REG_SOURCE_WIDTH, w);
		cfg_index <= nnd_pkg::REG_SOURCE_HEIGHT;
		cfg_data <= h;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(nnd_pkg::REG_SOURCE_HEIGHT, h);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [nnd_pkg::OP_W-1:0] noise_op();
		case ($urandom_range(0, 7))
			0: return nnd_pkg::OP_RESTART;
			1, 2: return OP_UNUSED;
			3, 4, 5: return nnd_pkg::OP_REPLAY;
			default: return nnd_pkg::OP_PUSH;
		endcase
	endfunction

	task automatic run_phase(logic [nnd_pkg::DIM_W-1:0] w, logic [nnd_pkg::DIM_W-1:0] h,
			int target, int noise);
		int counted;
		int roll;
		logic [nnd_pkg::OP_W-1:0] op;
		drain();
		set_dims(w, h);
		send_item(nnd_pkg::OP_RESTART, $urandom);
		counted = 0;
		while (counted < target) begin
			roll = $urandom_range(0, 99);
			if (sb.finished) op = (roll >= noise) ? nnd_pkg::OP_RESTART : noise_op();
			else if (sb.image_stuck()) op = (roll < 70) ? nnd_pkg::OP_RESTART : nnd_pkg::OP_PUSH;
			else if (roll < noise) op = noise_op();
			else if (sb.replay_applies()) op = nnd_pkg::OP_REPLAY;
			else op = nnd_pkg::OP_PUSH;
			idle_in();
			send_item(op, $urandom);
			if (item_counted) counted++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = '0;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		alpha_in = '0;
		stall_free = 1'b0;
		cycle_count = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unused op, empty replay, extreme pixels, missed replay, replay mid-row
		drain();
		set_dims(9'd4, 9'd2);
		send_item(OP_UNUSED, 32'hFFFF_FFFF);
		send_item(nnd_pkg::OP_REPLAY, 32'h0000_0000);
		send_item(nnd_pkg::OP_PUSH, 32'h0000_0000);
		send_item(nnd_pkg::OP_PUSH, 32'hFFFF_FFFF);
		send_item(nnd_pkg::OP_PUSH, 32'hF00F_5AA5);
		send_item(nnd_pkg::OP_PUSH, 32'hFE7F_8001);
		send_item(nnd_pkg::OP_REPLAY, 32'h0000_0000);
		repeat (4) send_item(nnd_pkg::OP_PUSH, $urandom);
		send_item(nnd_pkg::OP_REPLAY, 32'hFFFF_FFFF);
		send_item(nnd_pkg::OP_RESTART, 32'h0000_0000);
		repeat (2) send_item(nnd_pkg::OP_PUSH, $urandom);
		send_item(nnd_pkg::OP_REPLAY, $urandom);
		repeat (2) send_item(nnd_pkg::OP_PUSH, $urandom);
		send_item(nnd_pkg::OP_REPLAY, $urandom);

		// width lowered in the middle of a row
		drain();
		set_dims(9'd10, 9'd50);
		send_item(nnd_pkg::OP_RESTART, $urandom);
		repeat (6) send_item(nnd_pkg::OP_PUSH, $urandom);
		drain();
		set_dims(9'd4, 9'd50);
		repeat (5) send_item(nnd_pkg::OP_PUSH, $urandom);

		// zero width clamps to one, oversized height clamps to the line store depth
		drain();
		set_dims(9'd0, 9'd511);
		send_item(nnd_pkg::OP_RESTART, $urandom);
		repeat (6) send_item(nnd_pkg::OP_PUSH, $urandom);
		send_item(nnd_pkg::OP_REPLAY, $urandom);
		repeat (2) send_item(nnd_pkg::OP_PUSH, $urandom);

		// oversized width and zero height, whole image, then pixels after the image
		run_phase(9'd511, 9'd0, MAX_DIM + OUT_SIZE - 1, 0);
		send_item(nnd_pkg::OP_PUSH, $urandom);
		send_item(nnd_pkg::OP_REPLAY, $urandom);

		for (int i = 0; i < 3; i++) begin
			stall_free = (i % 3 == 0);
			run_phase(($urandom_range(0, 7) == 0) ? 9'($urandom_range(13, 40))
					: 9'($urandom_range(1, 6)),
				$urandom_range(0, 1) ? 9'($urandom_range(1, 20))
					: 9'($urandom_range(21, 70)),
				10, 12);
		end
		stall_free = 1'b0;

		drain();
		if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
